@@ rtl/core/i2a_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package i2a_pkg;

  // word and digit geometry
  localparam int unsigned WordW   = 32;
  localparam int unsigned NibW    = 4;
  localparam int unsigned DecDig  = 10;
  localparam int unsigned HexDig  = WordW / NibW;
  localparam int unsigned DigW    = DecDig * NibW;
  localparam int unsigned CntW    = 5;
  localparam int unsigned CharW   = 8;

  // format selector codes
  localparam logic [1:0] FmtUdec = 2'd0;
  localparam logic [1:0] FmtSdec = 2'd1;
  localparam logic [1:0] FmtHex  = 2'd2;

  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;

  typedef enum logic [1:0] {
    StIdle,
    StSign,
    StConv,
    StEmit
  } state_e;

  // map one nibble to its lowercase hex glyph
  function automatic logic [CharW-1:0] glyph(input logic [NibW-1:0] nib);
    logic [CharW-1:0] r;
    if (nib < 4'd10) begin
      r = ChZero + {4'd0, nib};
    end else begin
      r = ChLowA + {4'd0, nib - 4'd10};
    end
    return r;
  endfunction

  // double-dabble correction of one BCD digit
  function automatic logic [NibW-1:0] add3(input logic [NibW-1:0] d);
    logic [NibW-1:0] r;
    if (d >= 4'd5) begin
      r = d + 4'd3;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/integer_to_ascii_digits_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Hex: eight characters, one character per cycle, busy from the transfer until the last one.
// Decimal: optional sign character, a shift-and-correct pass over all 32 input bits, then
//   the 10 BCD digits in turn (a leading zero takes its turn without a strobe, except the last digit).
// One item at a time; start is taken only while busy_o is low. Results come on
//   strobe_o for one cycle each and cannot be stalled by the receiver.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops busy.
module integer_to_ascii_digits_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [1:0]                 cmd_i,
  input  wire logic [i2a_pkg::WordW-1:0]  value_i,
  output logic                            strobe_o,
  output logic [i2a_pkg::CharW-1:0]       char_out_o,
  output logic                            last_o
);

  i2a_pkg::state_e                 state_q, state_d;
  logic [i2a_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [i2a_pkg::WordW-1:0]       mag_q, mag_d;
  logic [i2a_pkg::DigW-1:0]        dig_q, dig_d;
  logic [i2a_pkg::DigW-1:0]        corr;
  logic                            hex_q, hex_d;
  logic                            seen_q, seen_d;
  logic [i2a_pkg::NibW-1:0]        top_nib;
  logic                            skip;
  logic                            neg;

  // correct every BCD digit ahead of the shift
  always_comb begin
    for (int i = 0; i < i2a_pkg::DecDig; i++) begin
      corr[i*i2a_pkg::NibW +: i2a_pkg::NibW] =
        i2a_pkg::add3(dig_q[i*i2a_pkg::NibW +: i2a_pkg::NibW]);
    end
  end

  assign top_nib = dig_q[i2a_pkg::DigW-1 -: i2a_pkg::NibW];
  assign skip    = !hex_q && !seen_q && (top_nib == '0) && (cnt_q != 5'd1);
  assign neg     = (cmd_i == i2a_pkg::FmtSdec) && value_i[i2a_pkg::WordW-1];

  // sequence: load, sign, convert, emit
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    mag_d      = mag_q;
    dig_d      = dig_q;
    hex_d      = hex_q;
    seen_d     = seen_q;
    strobe_o   = 1'b0;
    char_out_o = i2a_pkg::glyph(top_nib);
    last_o     = 1'b0;
    unique case (state_q)
      i2a_pkg::StIdle: begin
        if (start_i) begin
          seen_d = 1'b0;
          if (cmd_i[1]) begin
            hex_d   = 1'b1;
            dig_d   = {value_i, {(i2a_pkg::DigW - i2a_pkg::WordW){1'b0}}};
            cnt_d   = i2a_pkg::CntW'(i2a_pkg::HexDig);
            state_d = i2a_pkg::StEmit;
          end else begin
            hex_d   = 1'b0;
            dig_d   = '0;
            mag_d   = neg ? (i2a_pkg::WordW'(0) - value_i) : value_i;
            cnt_d   = i2a_pkg::CntW'(i2a_pkg::WordW - 1);
            state_d = neg ? i2a_pkg::StSign : i2a_pkg::StConv;
          end
        end
      end
      i2a_pkg::StSign: begin
        strobe_o   = 1'b1;
        char_out_o = i2a_pkg::ChMinus;
        state_d    = i2a_pkg::StConv;
      end
      i2a_pkg::StConv: begin
        dig_d = {corr[i2a_pkg::DigW-2:0], mag_q[i2a_pkg::WordW-1]};
        mag_d = {mag_q[i2a_pkg::WordW-2:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          cnt_d   = i2a_pkg::CntW'(i2a_pkg::DecDig);
          state_d = i2a_pkg::StEmit;
        end
      end
      i2a_pkg::StEmit: begin
        strobe_o = !skip;
        last_o   = (cnt_q == 5'd1);
        seen_d   = seen_q || !skip;
        dig_d    = {dig_q[i2a_pkg::DigW-i2a_pkg::NibW-1:0], {i2a_pkg::NibW{1'b0}}};
        cnt_d    = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          state_d = i2a_pkg::StIdle;
        end
      end
      default: state_d = i2a_pkg::StIdle;
    endcase
  end

  assign busy_o = (state_q != i2a_pkg::StIdle);

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2a_pkg::StIdle;
      cnt_q   <= '0;
      hex_q   <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hex_q   <= hex_d;
      seen_q  <= seen_d;
    end
  end

  // hold working data
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    dig_q <= dig_d;
  end

endmodule
`default_nettype wire

@@ rtl/core/i2a_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module i2a_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start_i,
  input wire logic                       busy_o,
  input wire logic [1:0]                 cmd_i,
  input wire logic [i2a_pkg::WordW-1:0]  value_i,
  input wire logic                       strobe_o,
  input wire logic [i2a_pkg::CharW-1:0]  char_out_o,
  input wire logic                       last_o
);

  // results only appear while an item is in work
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy_o) else $error("result outside of busy window");

  // a transfer makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("transfer did not raise busy");

  // the final character ends the item
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |=> !busy_o) else $error("busy after final character");

  // busy drops only after a final character
  a_fell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(strobe_o && last_o)) else $error("item ended without last");

  // a hex item starts with its first digit, never a sign
  a_hex_nosign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i[1]) |=> (strobe_o && char_out_o != i2a_pkg::ChMinus))
    else $error("hex item did not emit a digit first");

endmodule

bind integer_to_ascii_digits_top i2a_checker u_i2a_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .cmd_i      (cmd_i),
  .value_i    (value_i),
  .strobe_o   (strobe_o),
  .char_out_o (char_out_o),
  .last_o     (last_o)
);
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;

  // the selector code the block decodes by its high bit alone
  localparam logic [1:0] FmtSpare = 2'd3;
  localparam int unsigned RandWords = 250;
  localparam int unsigned QuietTail = 40;
  localparam int unsigned StallLimit = 500;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [1:0]                fmt;
    logic [i2a_pkg::WordW-1:0] word;
  } conv_req_t;

  typedef struct packed {
    logic [i2a_pkg::CharW-1:0] ch;
    logic                      last;
  } text_char_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic [1:0]                cmd_i = i2a_pkg::FmtUdec;
  logic [i2a_pkg::WordW-1:0] value_i = '0;
  logic                      busy_o;
  logic                      strobe_o;
  logic [i2a_pkg::CharW-1:0] char_out_o;
  logic                      last_o;

  conv_req_t  words_pending[$];
  text_char_t chars_due[$];
  string      hex_digits = "0123456789abcdef";

  int unsigned words_total = 0;
  int unsigned words_taken = 0;
  int unsigned words_handed = 0;
  int unsigned chars_checked = 0;
  int unsigned fmt_seen[4] = '{0, 0, 0, 0};
  int unsigned err_cnt = 0;
  int unsigned idle_left = 0;
  int unsigned stall_cnt = 0;

  integer_to_ascii_digits_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .strobe_o   (strobe_o),
    .char_out_o (char_out_o),
    .last_o     (last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // spell one word as the text the block should emit, most significant first
  function automatic void spell_word(input logic [1:0] fmt,
                                     input logic [i2a_pkg::WordW-1:0] word);
    logic [i2a_pkg::CharW-1:0] glyphs[$];
    logic [i2a_pkg::WordW-1:0] mag;
    logic                      neg;
    text_char_t                tc;
    if (fmt == i2a_pkg::FmtHex || fmt == FmtSpare) begin
      for (int k = 7; k >= 0; k--) begin
        glyphs.push_back(hex_digits[(word >> (k * 4)) & 32'hf]);
      end
    end else begin
      neg = (fmt == i2a_pkg::FmtSdec) && word[i2a_pkg::WordW-1];
      // the most negative value wraps to its own magnitude as unsigned
      mag = neg ? 32'd0 - word : word;
      do begin
        glyphs.push_front(i2a_pkg::ChZero + i2a_pkg::CharW'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (neg) begin
        glyphs.push_front(i2a_pkg::ChMinus);
      end
    end
    foreach (glyphs[i]) begin
      tc.ch = glyphs[i];
      tc.last = (i == glyphs.size() - 1);
      chars_due.push_back(tc);
    end
  endfunction

  function automatic void queue_word(input logic [1:0] fmt,
                                     input logic [i2a_pkg::WordW-1:0] word);
    conv_req_t req;
    req.fmt = fmt;
    req.word = word;
    words_pending.push_back(req);
    words_total++;
  endfunction

  // hand words to the block, with random idle bursts except near the end
  always @(negedge clk_i) begin : feed
    logic                      nx_start;
    logic [1:0]                nx_cmd;
    logic [i2a_pkg::WordW-1:0] nx_val;
    conv_req_t                 req;
    nx_start = start_i;
    nx_cmd = cmd_i;
    nx_val = value_i;
    if (start_i && words_taken != words_handed) begin
      words_handed++;
      nx_start = 1'b0;
    end
    if (!nx_start && rst_ni) begin
      if (idle_left > 0) begin
        idle_left--;
      end else if (words_pending.size() > 0) begin
        if (words_pending.size() > QuietTail && $urandom_range(0, 4) == 0) begin
          idle_left = $urandom_range(0, 10);
        end else begin
          req = words_pending.pop_front();
          nx_start = 1'b1;
          nx_cmd = req.fmt;
          nx_val = req.word;
        end
      end
    end
    // scramble the payload while nothing is offered
    if (!nx_start) begin
      nx_cmd = 2'($urandom);
      nx_val = $urandom;
    end
    start_i <= nx_start;
    cmd_i <= nx_cmd;
    value_i <= nx_val;
  end

  // check each emitted character, then record any new transfer
  always @(posedge clk_i) begin : watch
    text_char_t tc;
    if (rst_ni) begin
      if (strobe_o) begin
        if (chars_due.size() == 0) begin
          $error("unexpected character: char_out %h last %b", char_out_o, last_o);
          err_cnt++;
        end else begin
          tc = chars_due.pop_front();
          chars_checked++;
          if (char_out_o !== tc.ch) begin
            $error("char_out: expected %h actual %h", tc.ch, char_out_o);
            err_cnt++;
          end
          if (last_o !== tc.last) begin
            $error("last: expected %b actual %b", tc.last, last_o);
            err_cnt++;
          end
        end
      end
      if (start_i && !busy_o) begin
        spell_word(cmd_i, value_i);
        fmt_seen[cmd_i]++;
        words_taken++;
      end
    end
  end

  // give up when nothing moves for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || strobe_o || (start_i && !busy_o)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= StallLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [i2a_pkg::WordW-1:0] val;
    logic [i2a_pkg::WordW-1:0] pow;
    // directed: field extremes, digit-count edges, every format
    queue_word(i2a_pkg::FmtUdec, 32'd0);
    queue_word(i2a_pkg::FmtUdec, 32'hffff_ffff);
    queue_word(i2a_pkg::FmtUdec, 32'd9);
    queue_word(i2a_pkg::FmtUdec, 32'd10);
    queue_word(i2a_pkg::FmtUdec, 32'd999_999_999);
    queue_word(i2a_pkg::FmtUdec, 32'd1_000_000_000);
    queue_word(i2a_pkg::FmtSdec, 32'd0);
    queue_word(i2a_pkg::FmtSdec, 32'h8000_0000);
    queue_word(i2a_pkg::FmtSdec, 32'h7fff_ffff);
    queue_word(i2a_pkg::FmtSdec, 32'hffff_ffff);
    queue_word(i2a_pkg::FmtSdec, 32'hffff_fff6);
    queue_word(i2a_pkg::FmtSdec, 32'd5);
    queue_word(i2a_pkg::FmtSdec, 32'h8000_0001);
    queue_word(i2a_pkg::FmtHex, 32'd0);
    queue_word(i2a_pkg::FmtHex, 32'hffff_ffff);
    queue_word(i2a_pkg::FmtHex, 32'h0123_abcd);
    queue_word(i2a_pkg::FmtHex, 32'h89ab_cdef);
    queue_word(FmtSpare, 32'h89ab_cdef);
    queue_word(FmtSpare, 32'd0);
    queue_word(i2a_pkg::FmtUdec, 32'h8000_0000);

    // random words, shaped for varied digit counts and sign edges
    for (int n = 0; n < RandWords; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: val = $urandom;
        4, 5: val = $urandom >> $urandom_range(0, 31);
        6: begin
          pow = 1;
          repeat ($urandom_range(0, 9)) pow = pow * 10;
          val = pow + $urandom_range(0, 2) - 1;
        end
        7: val = 32'd0 - $urandom_range(1, 1000);
        8: val = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                       : 32'h7fff_ffff - $urandom_range(0, 3);
        default: val = $urandom & $urandom;
      endcase
      queue_word(2'($urandom_range(0, 3)), val);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain: all words taken, all characters seen, then a latency tail
    do @(posedge clk_i); while (words_pending.size() != 0 || words_taken != words_total);
    while (chars_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (chars_due.size() != 0) begin
      $error("%0d characters never emitted", chars_due.size());
      err_cnt++;
    end

    $display("converted %0d words: %0d unsigned, %0d signed, %0d hex, %0d spare-code hex",
             words_taken, fmt_seen[i2a_pkg::FmtUdec], fmt_seen[i2a_pkg::FmtSdec],
             fmt_seen[i2a_pkg::FmtHex], fmt_seen[FmtSpare]);
    $display("checked %0d characters, %0d mismatches", chars_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ integer_to_ascii_digits_top.f @@
rtl/core/i2a_pkg.sv
rtl/core/integer_to_ascii_digits_top.sv
rtl/core/i2a_checker.sv
verif/tb.sv
